/* hdl/dequ_pkg.sv */
// Shared types, constants and command codes for the double-ended queue.
package dequ_pkg;

    // Storage geometry
    localparam int CAPACITY = 16;
    localparam int CIDX_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // Command codes
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_REAR   = 3'd3;
    localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [2:0] CMD_LIST_ALL   = 3'd5;

    // Status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] value_res;
        logic                     last;
    } t_out_item;

    // Operation broadcast along the cell chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_RIGHT,
        CELL_SHIFT_LEFT,
        CELL_LOAD_AT,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

/* hdl/dequ_cell.sv */
// One storage cell of the queue chain: holds one element, trades with its neighbours.
module dequ_cell import dequ_pkg::*; (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic [CIDX_W-1:0]        i_index,
    input  logic signed [DATA_W-1:0] i_left,
    input  logic signed [DATA_W-1:0] i_right,
    input  logic signed [DATA_W-1:0] i_front,
    output logic signed [DATA_W-1:0] o_data
);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic [CNT_W-1:0]         w_pos;
    logic                     w_at_count;
    logic                     w_at_rear;

    // Locate this cell relative to the fill level
    assign w_pos      = CNT_W'(i_index);
    assign w_at_count = (w_pos == i_ctl.count);
    assign w_at_rear  = ((w_pos + CNT_W'(1)) == i_ctl.count);

    // Pick the next content from the broadcast operation
    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_SHIFT_RIGHT: n_data = i_left;
            CELL_SHIFT_LEFT:  n_data = i_right;
            CELL_LOAD_AT:     if (w_at_count) n_data = i_ctl.value;
            CELL_ROTATE:      n_data = w_at_rear ? i_front : i_right;
            default:          n_data = r_data;
        endcase
    end

    // Hold the element
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

/* hdl/double_ended_queue_unit.sv */
// Bounded double-ended queue of signed 32-bit values built as a chain of storage cells.
// The front element always sits in cell 0: a push at the front shifts the whole chain one
// cell towards the rear, a pop at the front shifts it back, a push at the rear loads the cell
// at the fill level and a pop at the rear reads the cell just below it. Push, pop, peek and
// unknown commands each load one result, and a new transaction can be taken every cycle
// while the result register drains. List produces one result per held element, one per
// cycle while the output does not stall, by rotating the occupied cells past cell 0; no
// command is taken until its last result has been loaded.
module double_ended_queue_unit import dequ_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_remain;
    logic [CNT_W-1:0] n_remain;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_item        r_out_data;
    t_out_item        n_out_data;

    t_cell_ctl                w_ctl;
    logic signed [DATA_W-1:0] w_cell [CAPACITY];
    logic [CNT_W-1:0]         w_rear_pos;
    logic                     w_can_load;
    logic                     w_in_acc;
    logic                     w_empty;
    logic                     w_full;

    // Cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        dequ_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_index (CIDX_W'(g)),
            .i_left  ((g == 0) ? w_ctl.value : w_cell[(g == 0) ? 0 : g - 1]),
            .i_right ((g == CAPACITY - 1) ? '0 : w_cell[(g == CAPACITY - 1) ? g : g + 1]),
            .i_front (w_cell[0]),
            .o_data  (w_cell[g])
        );
    end

    // Handshake
    assign w_can_load = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state == ST_LIST) || !w_can_load;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_rear_pos = r_count - CNT_W'(1);

    // Decode the transaction and steer the chain
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_remain    = r_remain;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        w_ctl.op    = CELL_HOLD;
        w_ctl.count = r_count;
        w_ctl.value = i_in_data.value;

        if (r_state == ST_LIST) begin
            if (w_can_load) begin
                n_out_valid          = 1'b1;
                n_out_data.status    = STS_OK;
                n_out_data.value_res = w_cell[0];
                n_out_data.last      = (r_remain == CNT_W'(1));
                w_ctl.op             = CELL_ROTATE;
                n_remain             = r_remain - CNT_W'(1);
                if (r_remain == CNT_W'(1)) n_state = ST_IDLE;
            end
        end else if (w_in_acc) begin
            n_out_valid          = 1'b1;
            n_out_data.status    = STS_OK;
            n_out_data.value_res = '0;
            n_out_data.last      = 1'b1;
            unique case (i_in_data.command) inside
                CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                    if (w_full) begin
                        n_out_data.status = STS_FULL;
                    end else begin
                        w_ctl.op = (i_in_data.command == CMD_PUSH_FRONT) ?
                                   CELL_SHIFT_RIGHT : CELL_LOAD_AT;
                        n_count  = r_count + CNT_W'(1);
                    end
                end
                CMD_POP_FRONT, CMD_PEEK_FRONT: begin
                    if (w_empty) begin
                        n_out_data.status = STS_EMPTY;
                    end else begin
                        n_out_data.value_res = w_cell[0];
                        if (i_in_data.command == CMD_POP_FRONT) begin
                            w_ctl.op = CELL_SHIFT_LEFT;
                            n_count  = r_count - CNT_W'(1);
                        end
                    end
                end
                CMD_POP_REAR: begin
                    if (w_empty) begin
                        n_out_data.status = STS_EMPTY;
                    end else begin
                        n_out_data.value_res = w_cell[w_rear_pos[CIDX_W-1:0]];
                        n_count              = w_rear_pos;
                    end
                end
                CMD_LIST_ALL: begin
                    if (w_empty) begin
                        n_out_data.status = STS_EMPTY;
                    end else begin
                        // Emit the front now, walk the rest by rotation
                        n_out_data.value_res = w_cell[0];
                        n_out_data.last      = (r_count == CNT_W'(1));
                        w_ctl.op             = CELL_ROTATE;
                        n_remain             = w_rear_pos;
                        if (r_count != CNT_W'(1)) n_state = ST_LIST;
                    end
                end
                default: begin
                    n_out_data.status = STS_OK;
                end
            endcase
        end
    end

    // Hold state, fill level and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill level beyond capacity");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_full && (i_in_data.command == CMD_PUSH_FRONT ||
         i_in_data.command == CMD_PUSH_REAR)) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("accepted push did not grow the queue");

    a_list_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIST) |=> (r_count == $past(r_count)))
        else $error("list walk changed the fill level");

    a_acc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_out_valid)
        else $error("accepted transaction produced no result");

    a_list_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIST) |-> (r_remain != '0 && r_remain < r_count))
        else $error("list walk counter out of range");
`endif

endmodule

/* bench/double_ended_queue_unit_tb.sv */
// Self-checking bench for the double-ended queue: directed table, biased random traffic.
module double_ended_queue_unit_tb import dequ_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // Command codes the block treats as no-ops
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    localparam int RANDOM_ITEMS = 222;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 2 * CAPACITY + 8;
    localparam int MAX_PRINTED  = 60;

    localparam logic [DATA_W-1:0] FILL_PATTERN [16] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'h0000_FFFF,
        32'hFFFF_0000, 32'h1234_5678, 32'h8765_4321, 32'h0000_0002,
        32'h4000_0000, 32'hBFFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0001
    };

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item res;
    } t_stim_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    // Directed rows, transactions in flight and results still owed
    t_stim_row stim_table[$];
    t_stim_row sent_rows[$];
    t_out_item owed_results[$];

    // Shadow copy of the queue contents
    logic signed [DATA_W-1:0] ring_mem [CAPACITY];
    int                       head_pos = 0;
    int                       fill     = 0;
    t_out_item                step_out [CAPACITY];

    int err_count    = 0;
    int quiet_cycles = 0;
    int stall_hold   = 0;
    int stall_tick   = 0;
    bit stall_calm   = 1'b0;

    double_ended_queue_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Apply one command to the shadow queue; fill step_out and return the result count
    function automatic int advance_deque(input t_in_item it);
        int pos;
        int n;
        n = 1;
        step_out[0].status    = STS_OK;
        step_out[0].value_res = '0;
        step_out[0].last      = 1'b1;
        case (it.command) inside
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                if (fill >= CAPACITY) begin
                    step_out[0].status = STS_FULL;
                end else begin
                    if (it.command == CMD_PUSH_FRONT) begin
                        head_pos = (head_pos + CAPACITY - 1) % CAPACITY;
                        pos      = head_pos;
                    end else begin
                        pos = (head_pos + fill) % CAPACITY;
                    end
                    ring_mem[pos] = it.value;
                    fill++;
                end
            end
            CMD_POP_FRONT, CMD_POP_REAR, CMD_PEEK_FRONT: begin
                if (fill == 0) begin
                    step_out[0].status = STS_EMPTY;
                end else begin
                    pos = (it.command == CMD_POP_REAR) ? (head_pos + fill - 1) % CAPACITY
                                                       : head_pos;
                    step_out[0].value_res = ring_mem[pos];
                    if (it.command == CMD_POP_FRONT)
                        head_pos = (head_pos + 1) % CAPACITY;
                    if (it.command != CMD_PEEK_FRONT)
                        fill--;
                end
            end
            CMD_LIST_ALL: begin
                if (fill == 0) begin
                    step_out[0].status = STS_EMPTY;
                end else begin
                    n = fill;
                    for (int i = 0; i < fill; i++) begin
                        step_out[i].status    = STS_OK;
                        step_out[i].value_res = ring_mem[(head_pos + i) % CAPACITY];
                        step_out[i].last      = (i == fill - 1);
                    end
                end
            end
            default: ;
        endcase
        return n;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [2:0] pick_command(input t_mix mix);
        int r;
        int push_cut;
        r = $urandom_range(0, 99);
        if (r < 3) return ($urandom_range(0, 1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
        if (r < 10) return CMD_LIST_ALL;
        if (r < 17) return CMD_PEEK_FRONT;
        push_cut = 17 + ((mix == MIX_FILL) ? 58 : (mix == MIX_DRAIN) ? 17 : 41);
        if (r < push_cut)
            return ($urandom_range(0, 1) != 0) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
        return ($urandom_range(0, 1) != 0) ? CMD_POP_REAR : CMD_POP_FRONT;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(input logic [2:0] cmd, input logic signed [DATA_W-1:0] val,
                           input bit typed, input logic [1:0] st);
        t_stim_row row;
        row.item.command  = cmd;
        row.item.value    = val;
        row.typed         = typed;
        row.res.status    = st;
        row.res.value_res = '0;
        row.res.last      = 1'b1;
        stim_table.push_back(row);
    endtask

    task automatic flag_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Offer one transaction after a gap and hold it until it is taken
    task automatic drive_item(input t_stim_row row, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sent_rows.push_back(row);
        i_in_data  <= row.item;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    // Hold the sender until every owed result has been taken
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sent_rows.size() != 0 || owed_results.size() != 0) @(posedge i_clk);
    endtask

    // Predict on input transactions, check output transactions
    always @(posedge i_clk) begin : scoreboard
        t_stim_row row;
        t_out_item got;
        t_out_item want;
        int        n;
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall === 1'b0) begin
                row.typed = 1'b0;
                if (sent_rows.size() != 0)
                    row = sent_rows.pop_front();
                n = advance_deque(i_in_data);
                if (row.typed) begin
                    owed_results.push_back(row.res);
                end else begin
                    for (int i = 0; i < n; i++)
                        owed_results.push_back(step_out[i]);
                end
            end
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                got = o_out_data;
                if (owed_results.size() == 0) begin
                    flag_mismatch($sformatf("result %0h with nothing expected", got));
                end else begin
                    want = owed_results.pop_front();
                    if (got.status !== want.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                got.status, want.status));
                    if (got.value_res !== want.value_res)
                        flag_mismatch($sformatf("value_res %0h, expected %0h",
                                                got.value_res, want.value_res));
                    if (got.last !== want.last)
                        flag_mismatch($sformatf("last %0b, expected %0b",
                                                got.last, want.last));
                end
            end
        end
    end

    // Random downstream stall with calm stretches
    always @(posedge i_clk) begin
        stall_tick++;
        if (stall_tick % 64 == 0)
            stall_calm = ($urandom_range(0, 3) == 0);
        if (stall_hold > 0) begin
            stall_hold--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            stall_hold = stall_calm ? 0 : idle_len();
        end
    end

    // Abort if no transaction moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        t_stim_row row;
        t_mix      mix;
        bit        calm;
        mix  = MIX_FILL;
        calm = 1'b0;

        // Empty queue answers and spare commands
        add_row(CMD_POP_FRONT,  VAL_MAX, 1'b1, STS_EMPTY);
        add_row(CMD_POP_REAR,   VAL_MIN, 1'b1, STS_EMPTY);
        add_row(CMD_PEEK_FRONT, '0,      1'b1, STS_EMPTY);
        add_row(CMD_LIST_ALL,   '1,      1'b1, STS_EMPTY);
        add_row(CMD_SPARE_6,    VAL_MAX, 1'b1, STS_OK);
        add_row(CMD_SPARE_7,    '1,      1'b1, STS_OK);
        // Fill to capacity from both ends, then push into a full queue
        for (int i = 0; i < CAPACITY; i++)
            add_row((i % 2 != 0) ? CMD_PUSH_REAR : CMD_PUSH_FRONT,
                    FILL_PATTERN[i % 16], 1'b1, STS_OK);
        add_row(CMD_PUSH_FRONT, VAL_MIN, 1'b1, STS_FULL);
        add_row(CMD_PUSH_REAR,  VAL_MAX, 1'b1, STS_FULL);
        // Read back the full queue
        add_row(CMD_PEEK_FRONT, '0, 1'b0, STS_OK);
        add_row(CMD_LIST_ALL,   '0, 1'b0, STS_OK);
        add_row(CMD_POP_FRONT,  '0, 1'b0, STS_OK);
        add_row(CMD_POP_REAR,   '0, 1'b0, STS_OK);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[k])
            drive_item(stim_table[k], idle_len());
        wait_drained();

        // Random traffic in phases that lean towards filling, draining or neither
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 30 == 0) begin
                mix  = t_mix'($urandom_range(0, 2));
                calm = ($urandom_range(0, 3) == 0);
            end
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            row.item.command = pick_command(mix);
            row.item.value   = pick_value();
            row.typed        = 1'b0;
            row.res          = '0;
            drive_item(row, calm ? 0 : idle_len());
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && owed_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* double_ended_queue_unit.f */
hdl/dequ_pkg.sv
hdl/dequ_cell.sv
hdl/double_ended_queue_unit.sv
bench/double_ended_queue_unit_tb.sv
